### design/ffa_pkg.sv
package ffa_pkg;

  localparam int HEAP_UNITS = 1024;
  localparam int UNIT_BYTES = 8;
  localparam int UNIT_SHIFT = $clog2(UNIT_BYTES);
  localparam int IDX_W      = $clog2(HEAP_UNITS + 1);
  localparam int BYTES_W    = 16;
  localparam int NEED_W     = BYTES_W + 1 - UNIT_SHIFT;
  localparam int CFG_IDX_W  = 2;

  localparam logic [2:0] CMD_ALLOC   = 3'd0;
  localparam logic [2:0] CMD_FREE    = 3'd1;
  localparam logic [2:0] CMD_REALLOC = 3'd2;
  localparam logic [2:0] CMD_QUERY   = 3'd3;
  localparam logic [2:0] CMD_REINIT  = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OOM  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_HEAP_UNITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GUARD_MODE = 2'd1;

  typedef struct packed {
    logic [2:0]         command;
    logic [BYTES_W-1:0] request_bytes;
    logic [IDX_W-1:0]   block_handle;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0]   result_handle;
    logic [1:0]         status;
    logic [IDX_W-1:0]   allocated_units;
    logic [BYTES_W-1:0] largest_free_bytes;
  } out_t;

endpackage

### design/first_fit_free_list_allocator.sv
// Alloc walks the free list from the rover, adding a tail-write step when the block is split;
// free checks the handle and walks to the insertion point, with no link step on merge with the
// lower block; query walks the list; a moving reallocate does both, an in-place one only the check.
// Throughput: one item at a time; the header memory read port, one node per cycle, sets it.
// Reset and reinitialize run a clearing pass over all HEAP_UNITS + 1 live flags,
// busy high meanwhile; reinitialize answers after the pass, reset does not.
module first_fit_free_list_allocator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  ffa_pkg::in_t                    in_data,
  output logic                            out_valid,
  output ffa_pkg::out_t                   out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ffa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ffa_pkg::IDX_W-1:0]       cfg_data
);
  import ffa_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0] size;
    logic [IDX_W-1:0] link;
  } hdr_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_CHK, S_HEAD, S_WALK, S_TAIL,
    S_F0, S_F1, S_F2, S_F3, S_Q
  } state_t;

  localparam logic [IDX_W-1:0] HU = IDX_W'(HEAP_UNITS);

  hdr_t             hdr_mem [0:HEAP_UNITS];
  logic             live_mem [0:HEAP_UNITS];

  state_t           state_r;
  logic [IDX_W-1:0] heap_units_r;
  logic             guard_r;
  logic [IDX_W-1:0] sentinel_r, rover_r, units_r;
  logic [IDX_W-1:0] clr_r;
  logic [2:0]       cmd_r;
  logic [IDX_W-1:0] h_r;
  logic [NEED_W-1:0] need_r;
  logic [IDX_W-1:0] prev_r, prev_size_r, cur_r, tail_r;
  logic [IDX_W-1:0] blk_r, blk_size_r, at_r, at_size_r, nx_r;
  logic [IDX_W-1:0] best_r;
  logic             move_r, report_r;
  logic             out_valid_r;
  logic [IDX_W-1:0] res_r;
  logic [1:0]       status_r;
  logic [BYTES_W-1:0] largest_r;

  hdr_t             hrd_r;
  logic [IDX_W-1:0] rdi_r;
  logic             lrd_r;

  logic [IDX_W-1:0] hra, hu_clamp, hclamp;
  logic             hwe, lwe, lwd;
  logic [IDX_W-1:0] hwa, lwa;
  hdr_t             hwd;

  logic [IDX_W-1:0] size_d, link_d;
  logic             fit, exact, walk_end, brk, merge_n, merge_p, live_ok;
  logic [IDX_W-1:0] rem, bsz2, blink2, bmax;
  logic [IDX_W:0]   tail_w;
  logic [NEED_W-1:0] need_nxt;
  logic [BYTES_W+2:0] best_bytes;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = '{result_handle: res_r, status: status_r,
                       allocated_units: units_r, largest_free_bytes: largest_r};

  // Header word as seen through the sentinel at index zero.
  assign size_d = (rdi_r == '0 || rdi_r > HU) ? '0 : hrd_r.size;
  assign link_d = (rdi_r == '0) ? sentinel_r : hrd_r.link;

  assign fit      = (cur_r <= HU) && ({{(NEED_W-IDX_W){1'b0}}, size_d} >= need_r);
  assign exact    = ({{(NEED_W-IDX_W){1'b0}}, size_d} == need_r);
  assign rem      = size_d - need_r[IDX_W-1:0];
  assign tail_w   = {1'b0, cur_r} + {1'b0, rem};
  assign walk_end = (cur_r == rover_r) || (cur_r > HU);

  assign brk = ((blk_r > at_r) && (blk_r < link_d)) ||
               ((at_r >= link_d) && ((blk_r > at_r) || (blk_r < link_d)));
  assign merge_n = (nx_r != '0) && (({1'b0, blk_r} + {1'b0, blk_size_r}) == {1'b0, nx_r});
  assign bsz2    = merge_n ? blk_size_r + size_d : blk_size_r;
  assign blink2  = merge_n ? link_d : nx_r;
  assign merge_p = (at_r != '0) && (({1'b0, at_r} + {1'b0, at_size_r}) == {1'b0, blk_r});

  assign live_ok = (h_r >= IDX_W'(2)) && (h_r <= HU) && lrd_r;
  assign bmax    = (size_d > best_r) ? size_d : best_r;
  assign best_bytes = (BYTES_W+3)'(bmax) << UNIT_SHIFT;

  assign need_nxt = NEED_W'(1)
                  + NEED_W'(({1'b0, in_data.request_bytes} + (BYTES_W+1)'(UNIT_BYTES - 1))
                            >> UNIT_SHIFT)
                  + NEED_W'(guard_r);

  always_comb begin
    if (heap_units_r < IDX_W'(4)) hu_clamp = IDX_W'(4);
    else if (heap_units_r > HU)   hu_clamp = HU;
    else                          hu_clamp = heap_units_r;
  end

  assign hclamp = (in_data.block_handle != '0 && in_data.block_handle - 1'b1 <= HU) ?
                  in_data.block_handle - 1'b1 : '0;

  always_comb begin
    unique case (state_r)
      S_IDLE: begin
        if (in_data.command == CMD_FREE ||
            (in_data.command == CMD_REALLOC && in_data.block_handle != '0)) begin
          hra = hclamp;
        end else begin
          hra = rover_r;
        end
      end
      S_CHK, S_F0: hra = rover_r;
      default:     hra = (link_d > HU) ? '0 : link_d;
    endcase
  end

  // Memory write ports.
  always_comb begin
    hwe = 1'b0;
    hwa = '0;
    hwd = '0;
    lwe = 1'b0;
    lwa = '0;
    lwd = 1'b0;
    unique case (state_r)
      S_CLR: begin
        lwe = 1'b1;
        lwa = clr_r;
        if (clr_r == '0) begin
          hwe = 1'b1;
          hwa = IDX_W'(1);
          hwd = '{size: hu_clamp, link: '0};
        end
      end
      S_WALK: begin
        if (fit && exact) begin
          hwe = (prev_r != '0);
          hwa = prev_r;
          hwd = '{size: prev_size_r, link: link_d};
          lwe = 1'b1;
          lwa = cur_r;
          lwd = 1'b1;
        end else if (fit) begin
          hwe = 1'b1;
          hwa = cur_r;
          hwd = '{size: rem, link: link_d};
        end
      end
      S_TAIL: begin
        hwe = 1'b1;
        hwa = tail_r;
        hwd = '{size: need_r[IDX_W-1:0], link: '0};
        lwe = 1'b1;
        lwa = tail_r;
        lwd = 1'b1;
      end
      S_F0: begin
        lwe = 1'b1;
        lwa = blk_r;
      end
      S_F2: begin
        hwe = 1'b1;
        if (merge_p) begin
          hwa = at_r;
          hwd = '{size: at_size_r + bsz2, link: blink2};
        end else begin
          hwa = blk_r;
          hwd = '{size: bsz2, link: blink2};
        end
      end
      S_F3: begin
        hwe = (at_r != '0);
        hwa = at_r;
        hwd = '{size: at_size_r, link: blk_r};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (hwe) hdr_mem[hwa] <= hwd;
    if (lwe) live_mem[lwa] <= lwd;
    hrd_r <= hdr_mem[hra];
    lrd_r <= live_mem[hra];
    rdi_r <= hra;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      heap_units_r <= HU;
      guard_r      <= 1'b0;
      clr_r        <= '0;
      report_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      sentinel_r   <= IDX_W'(1);
      rover_r      <= '0;
      units_r      <= '0;
      move_r       <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_HEAP_UNITS)      heap_units_r <= cfg_data;
        else if (cfg_index == REG_GUARD_MODE) guard_r      <= cfg_data[0];
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            cmd_r     <= in_data.command;
            h_r       <= in_data.block_handle;
            need_r    <= need_nxt;
            move_r    <= 1'b0;
            res_r     <= '0;
            status_r  <= ST_OK;
            largest_r <= '0;
            blk_r     <= hclamp;
            case (in_data.command)
              CMD_ALLOC, CMD_REALLOC: begin
                if (in_data.request_bytes == '0) begin
                  status_r    <= ST_ZERO;
                  out_valid_r <= 1'b1;
                end else if (in_data.command == CMD_REALLOC &&
                             in_data.block_handle != '0) begin
                  state_r <= S_CHK;
                end else begin
                  state_r <= S_HEAD;
                end
              end
              CMD_FREE:   state_r <= S_CHK;
              CMD_QUERY:  state_r <= S_HEAD;
              CMD_REINIT: begin
                clr_r    <= '0;
                report_r <= 1'b1;
                state_r  <= S_CLR;
              end
              default: out_valid_r <= 1'b1;
            endcase
          end
        end
        S_CLR: begin
          if (clr_r == '0) begin
            sentinel_r <= IDX_W'(1);
            rover_r    <= '0;
            units_r    <= '0;
          end
          clr_r <= clr_r + 1'b1;
          if (clr_r == HU) begin
            state_r     <= S_IDLE;
            out_valid_r <= report_r;
            report_r    <= 1'b0;
          end
        end
        S_CHK: begin
          blk_size_r <= hrd_r.size;
          if (!live_ok) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
          end else if (cmd_r == CMD_FREE) begin
            state_r <= S_F0;
          end else if (need_r > {{(NEED_W-IDX_W){1'b0}}, hrd_r.size}) begin
            move_r  <= 1'b1;
            state_r <= S_HEAD;
          end else begin
            res_r       <= h_r;
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
          end
        end
        S_HEAD: begin
          prev_r      <= rover_r;
          prev_size_r <= size_d;
          cur_r       <= link_d;
          best_r      <= '0;
          state_r     <= (cmd_r == CMD_QUERY) ? S_Q : S_WALK;
        end
        S_WALK: begin
          if (fit) begin
            if (exact) begin
              if (prev_r == '0) sentinel_r <= link_d;
              rover_r <= prev_r;
              units_r <= units_r + need_r[IDX_W-1:0];
              res_r   <= cur_r + 1'b1;
              if (move_r) begin
                state_r <= S_F0;
              end else begin
                state_r     <= S_IDLE;
                out_valid_r <= 1'b1;
              end
            end else if (tail_w > {1'b0, HU}) begin
              status_r    <= ST_OOM;
              state_r     <= S_IDLE;
              out_valid_r <= 1'b1;
            end else begin
              tail_r  <= tail_w[IDX_W-1:0];
              state_r <= S_TAIL;
            end
          end else if (walk_end) begin
            status_r    <= ST_OOM;
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
          end else begin
            prev_r      <= cur_r;
            prev_size_r <= size_d;
            cur_r       <= link_d;
          end
        end
        S_TAIL: begin
          rover_r <= prev_r;
          units_r <= units_r + need_r[IDX_W-1:0];
          res_r   <= tail_r + 1'b1;
          if (move_r) begin
            state_r <= S_F0;
          end else begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
          end
        end
        S_F0: begin
          units_r <= units_r - blk_size_r;
          at_r    <= rover_r;
          state_r <= S_F1;
        end
        S_F1: begin
          // Advance until blk falls between at and its successor.
          if (brk) begin
            at_size_r <= size_d;
            nx_r      <= link_d;
            state_r   <= S_F2;
          end else begin
            at_r <= link_d;
          end
        end
        S_F2: begin
          if (merge_p) begin
            rover_r     <= at_r;
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
          end else begin
            state_r <= S_F3;
          end
        end
        S_F3: begin
          if (at_r == '0) sentinel_r <= blk_r;
          rover_r     <= at_r;
          state_r     <= S_IDLE;
          out_valid_r <= 1'b1;
        end
        S_Q: begin
          best_r <= bmax;
          if (walk_end) begin
            largest_r   <= (best_bytes > (BYTES_W+3)'(16'hFFFF)) ? 16'hFFFF :
                           best_bytes[BYTES_W-1:0];
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
          end else begin
            cur_r <= link_d;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### verif/tb_top.sv
module tb_top;
  import ffa_pkg::*;

  localparam int ALLOC_TIMEOUT = 20000;
  localparam int RANDOM_ITEMS  = 900;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t in_data;
  logic out_valid;
  out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [IDX_W-1:0] cfg_data;

  first_fit_free_list_allocator dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // heap shadow
  int unsigned hdr_size [0:HEAP_UNITS];
  int unsigned hdr_link [0:HEAP_UNITS];
  bit          blk_live [0:HEAP_UNITS];
  int unsigned head_next, rover, in_use;
  int unsigned heap_cfg, guard_cfg;
  out_t        pending_results[$];
  int unsigned live_handles[$];
  int errors, n_items, n_results, n_oom;
  int watchdog = 0;
  bit idle_enable;

  function automatic int unsigned link_at(int unsigned i);
    return (i == 0) ? head_next : hdr_link[i];
  endfunction

  function automatic void set_link_at(int unsigned i, int unsigned v);
    if (i == 0) head_next = v;
    else hdr_link[i] = v;
  endfunction

  function automatic int unsigned size_at(int unsigned i);
    return (i == 0 || i > HEAP_UNITS) ? 0 : hdr_size[i];
  endfunction

  function automatic void heap_clear();
    int unsigned hu;
    hu = heap_cfg < 4 ? 4 : (heap_cfg > HEAP_UNITS ? HEAP_UNITS : heap_cfg);
    for (int i = 0; i <= HEAP_UNITS; i++) begin
      hdr_size[i] = 0;
      hdr_link[i] = 0;
      blk_live[i] = 0;
    end
    hdr_size[1] = hu;
    head_next = 1;
    rover = 0;
    in_use = 0;
    live_handles.delete();
  endfunction

  function automatic int unsigned units_for(int unsigned bytes);
    return 1 + (bytes + UNIT_BYTES - 1) / UNIT_BYTES + guard_cfg;
  endfunction

  function automatic int unsigned carve(int unsigned bytes);
    int unsigned need, prev, cur;
    need = units_for(bytes);
    prev = rover;
    cur = link_at(prev);
    for (int g = 0; g < HEAP_UNITS + 2; g++) begin
      if (cur <= HEAP_UNITS && size_at(cur) >= need) begin
        if (size_at(cur) == need) begin
          set_link_at(prev, link_at(cur));
        end else begin
          hdr_size[cur] -= need;
          cur += hdr_size[cur];
          if (cur > HEAP_UNITS) return 0;
          hdr_size[cur] = need;
        end
        rover = prev;
        in_use += need;
        blk_live[cur] = 1;
        live_handles.push_back(cur + 1);
        return cur + 1;
      end
      if (cur == rover || cur > HEAP_UNITS) return 0;
      prev = cur;
      cur = link_at(cur);
    end
    return 0;
  endfunction

  function automatic bit is_live(int unsigned h);
    return h >= 2 && h <= HEAP_UNITS && blk_live[h-1];
  endfunction

  function automatic void release_block(int unsigned h);
    int unsigned blk, at, nx;
    blk = h - 1;
    at = rover;
    blk_live[blk] = 0;
    in_use -= hdr_size[blk];
    for (int i = 0; i < live_handles.size(); i++)
      if (live_handles[i] == h) begin
        live_handles.delete(i);
        break;
      end
    for (int g = 0; g < HEAP_UNITS + 2; g++) begin
      nx = link_at(at);
      if (blk > at && blk < nx) break;
      if (at >= nx && (blk > at || blk < nx)) break;
      at = nx;
      if (at > HEAP_UNITS) begin
        at = 0;
        break;
      end
    end
    nx = link_at(at);
    if (nx != 0 && blk + hdr_size[blk] == nx) begin
      hdr_size[blk] += size_at(nx);
      hdr_link[blk] = link_at(nx);
    end else begin
      hdr_link[blk] = nx;
    end
    if (at != 0 && at + hdr_size[at] == blk) begin
      hdr_size[at] += hdr_size[blk];
      set_link_at(at, hdr_link[blk]);
    end else begin
      set_link_at(at, blk);
    end
    rover = at;
  endfunction

  function automatic int unsigned largest_bytes();
    int unsigned best, cur;
    best = 0;
    cur = link_at(rover);
    for (int g = 0; g < HEAP_UNITS + 2; g++) begin
      if (size_at(cur) > best) best = size_at(cur);
      if (cur == rover || cur > HEAP_UNITS) break;
      cur = link_at(cur);
    end
    best *= UNIT_BYTES;
    return best > 65535 ? 65535 : best;
  endfunction

  function automatic out_t predict_alloc(in_t it);
    out_t r;
    int unsigned h, b;
    r = '0;
    h = it.block_handle;
    b = it.request_bytes;
    case (it.command)
      CMD_ALLOC: begin
        if (b == 0) r.status = ST_ZERO;
        else begin
          r.result_handle = IDX_W'(carve(b));
          if (r.result_handle == 0) r.status = ST_OOM;
        end
      end
      CMD_FREE: if (is_live(h)) release_block(h);
      CMD_REALLOC: begin
        if (b == 0) r.status = ST_ZERO;
        else if (h == 0) begin
          r.result_handle = IDX_W'(carve(b));
          if (r.result_handle == 0) r.status = ST_OOM;
        end else if (is_live(h)) begin
          if (units_for(b) > hdr_size[h-1]) begin
            r.result_handle = IDX_W'(carve(b));
            if (r.result_handle == 0) r.status = ST_OOM;
            else release_block(h);
          end else begin
            r.result_handle = IDX_W'(h);
          end
        end
      end
      CMD_QUERY: r.largest_free_bytes = BYTES_W'(largest_bytes());
      CMD_REINIT: heap_clear();
      default: ;
    endcase
    r.allocated_units = IDX_W'(in_use);
    if (r.status == ST_OOM) n_oom++;
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("MISMATCH item %0d %s: got %0d expected %0d", n_results, what, got, want);
    errors++;
  endtask

  task automatic check_row(out_t p, out_t f);
    if (p.result_handle !== f.result_handle)
      report_mismatch("row result_handle", p.result_handle, f.result_handle);
    if (p.status !== f.status)
      report_mismatch("row status", p.status, f.status);
    if (p.allocated_units !== f.allocated_units)
      report_mismatch("row allocated_units", p.allocated_units, f.allocated_units);
    if (p.largest_free_bytes !== f.largest_free_bytes)
      report_mismatch("row largest_free_bytes", p.largest_free_bytes, f.largest_free_bytes);
  endtask

  // result checker and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) watchdog <= 0;
      else watchdog <= watchdog + 1;
      if (watchdog > ALLOC_TIMEOUT) begin
        $display("timeout after %0d idle cycles", watchdog);
        $display("first_fit_free_list_allocator test failed");
        $finish;
      end
    end
    if (out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        out_t w;
        w = pending_results.pop_front();
        if (out_data.result_handle !== w.result_handle)
          report_mismatch("result_handle", out_data.result_handle, w.result_handle);
        if (out_data.status !== w.status)
          report_mismatch("status", out_data.status, w.status);
        if (out_data.allocated_units !== w.allocated_units)
          report_mismatch("allocated_units", out_data.allocated_units, w.allocated_units);
        if (out_data.largest_free_bytes !== w.largest_free_bytes)
          report_mismatch("largest_free_bytes", out_data.largest_free_bytes,
                          w.largest_free_bytes);
      end
      n_results++;
    end
  end

  // drop start while idling
  task automatic gap();
    if (idle_enable)
      while ($urandom_range(99) < 27) begin
        start <= 1'b0;
        @(posedge clk);
      end
  endtask

  // drive one item; a typed-in row is checked against the predictor
  task automatic issue(in_t it, bit has_fixed, out_t fixed);
    out_t p;
    gap();
    start <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    p = predict_alloc(it);
    if (has_fixed) check_row(p, fixed);
    pending_results.push_back(p);
    n_items++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= IDX_W'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_HEAP_UNITS) heap_cfg = val;
    else guard_cfg = val & 1;
  endtask

  function automatic in_t mk(logic [2:0] c, int unsigned b, int unsigned h);
    in_t it;
    it.command = c;
    it.request_bytes = BYTES_W'(b);
    it.block_handle = IDX_W'(h);
    return it;
  endfunction

  function automatic out_t res(int unsigned h, logic [1:0] s, int unsigned u, int unsigned l);
    out_t r;
    r.result_handle = IDX_W'(h);
    r.status = s;
    r.allocated_units = IDX_W'(u);
    r.largest_free_bytes = BYTES_W'(l);
    return r;
  endfunction

  function automatic in_t random_item();
    int unsigned pick, b, h;
    pick = $urandom_range(99);
    b = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(1, 300);
    if ($urandom_range(40) == 0) b = 0;
    h = live_handles.size() ? live_handles[$urandom_range(live_handles.size() - 1)] : 0;
    if ($urandom_range(15) == 0) h = $urandom_range(2047);
    if (pick < 42) return mk(CMD_ALLOC, b, 0);
    if (pick < 72) return mk(CMD_FREE, 0, h);
    if (pick < 87) return mk(CMD_REALLOC, b, ($urandom_range(9) == 0) ? 0 : h);
    if (pick < 95) return mk(CMD_QUERY, $urandom_range(65535), $urandom_range(2047));
    if (pick < 97) return mk(CMD_REINIT, 0, 0);
    return mk(3'($urandom_range(5, 7)), $urandom_range(65535), $urandom_range(2047));
  endfunction

  typedef struct {
    in_t  stim;
    bit   has_fixed;
    out_t fixed;
  } dir_row_t;

  dir_row_t dir_rows[$];

  initial begin
    out_t none;
    none = '0;
    errors = 0; n_items = 0; n_results = 0; n_oom = 0;
    idle_enable = 1;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    heap_cfg = 1024;
    guard_cfg = 0;
    heap_clear();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // fresh 1024-unit heap: allocations carve from the tail
    dir_rows.push_back('{mk(CMD_QUERY, 0, 0), 1, res(0, ST_OK, 0, 8192)});
    dir_rows.push_back('{mk(CMD_ALLOC, 0, 0), 1, res(0, ST_ZERO, 0, 0)});
    dir_rows.push_back('{mk(CMD_REALLOC, 0, 5), 1, res(0, ST_ZERO, 0, 0)});
    dir_rows.push_back('{mk(CMD_ALLOC, 1, 0), 1, res(1024, ST_OK, 2, 0)});
    dir_rows.push_back('{mk(CMD_ALLOC, 65535, 0), 1, res(0, ST_OOM, 2, 0)});
    dir_rows.push_back('{mk(CMD_FREE, 0, 0), 1, res(0, ST_OK, 2, 0)});
    dir_rows.push_back('{mk(CMD_FREE, 0, 2047), 1, res(0, ST_OK, 2, 0)});
    dir_rows.push_back('{mk(CMD_FREE, 0, 500), 1, res(0, ST_OK, 2, 0)});
    dir_rows.push_back('{mk(CMD_REALLOC, 8, 1024), 1, res(1024, ST_OK, 2, 0)});
    dir_rows.push_back('{mk(CMD_REALLOC, 100, 0), 0, none});
    dir_rows.push_back('{mk(CMD_REALLOC, 200, 1024), 0, none});
    dir_rows.push_back('{mk(CMD_ALLOC, 16, 0), 0, none});
    dir_rows.push_back('{mk(CMD_QUERY, 65535, 2047), 0, none});
    dir_rows.push_back('{mk(3'd5, 65535, 2047), 0, none});
    dir_rows.push_back('{mk(3'd7, 0, 0), 0, none});
    dir_rows.push_back('{mk(CMD_ALLOC, 8000, 0), 0, none});
    dir_rows.push_back('{mk(CMD_REINIT, 0, 0), 1, res(0, ST_OK, 0, 0)});
    dir_rows.push_back('{mk(CMD_ALLOC, 8176, 0), 1, res(3, ST_OK, 1023, 0)});
    dir_rows.push_back('{mk(CMD_FREE, 0, 3), 1, res(0, ST_OK, 0, 0)});
    dir_rows.push_back('{mk(CMD_ALLOC, 8184, 0), 1, res(2, ST_OK, 1024, 0)});
    dir_rows.push_back('{mk(CMD_REINIT, 0, 0), 1, res(0, ST_OK, 0, 0)});
    foreach (dir_rows[i]) issue(dir_rows[i].stim, dir_rows[i].has_fixed, dir_rows[i].fixed);
    drain();

    // several heap and guard settings, extremes included; reinit applies heap size
    for (int ph = 0; ph < 6; ph++) begin
      int unsigned hu;
      case (ph)
        0: hu = 4;
        1: hu = 1024;
        2: hu = 2047;
        3: hu = 0;
        default: hu = $urandom_range(4, 200);
      endcase
      write_reg(REG_HEAP_UNITS, hu);
      write_reg(REG_GUARD_MODE, ph % 2);
      issue(mk(CMD_REINIT, 0, 0), 0, none);
      idle_enable = (ph != 1);
      for (int k = 0; k < RANDOM_ITEMS / 6; k++) issue(random_item(), 0, none);
      drain();
    end
    idle_enable = 1;

    $display("covered %0d items, %0d results, %0d out-of-memory answers",
             n_items, n_results, n_oom);
    if (errors == 0) begin
      $display("first_fit_free_list_allocator test passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("first_fit_free_list_allocator test failed");
    end
    $finish;
  end

endmodule

### filelist.f
design/ffa_pkg.sv
design/first_fit_free_list_allocator.sv
verif/tb_top.sv
